// File: rtl/core/hrfe_pkg.sv
// Shared types, constants and helper functions for the HTTP request field extractor.
// Holds the byte codes, status and selector codes, the keyword table and a saturating increment.
// No dependencies.
package hrfe_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_PARAM     = 2'd2;

    typedef logic [1:0] sel_t;
    localparam sel_t SEL_URL    = 2'd0;
    localparam sel_t SEL_HOST   = 2'd1;
    localparam sel_t SEL_METHOD = 2'd2;
    localparam sel_t SEL_BAD    = 2'd3;

    // keyword flag bits
    localparam int KW_GET  = 0;
    localparam int KW_POST = 1;
    localparam int KW_HEAD = 2;
    localparam int KW_HOST = 3;
    localparam int KW_NUM  = 4;

    typedef logic [KW_NUM-1:0] kw_flags_t;

    // length of keyword k
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        case (k)
            2'd0:    len = 3'd3;
            2'd1:    len = 3'd4;
            2'd2:    len = 3'd4;
            default: len = 3'd5;
        endcase
        return len;
    endfunction

    // character at position p of keyword k
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0:
            begin
                case (p)
                    3'd0:    c = "G";
                    3'd1:    c = "E";
                    3'd2:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (p)
                    3'd0:    c = "P";
                    3'd1:    c = "O";
                    3'd2:    c = "S";
                    3'd3:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (p)
                    3'd0:    c = "H";
                    3'd1:    c = "E";
                    3'd2:    c = "A";
                    3'd3:    c = "D";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (p)
                    3'd0:    c = "H";
                    3'd1:    c = "o";
                    3'd2:    c = "s";
                    3'd3:    c = "t";
                    3'd4:    c = ":";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] cap);
        return (v >= cap) ? cap : v + 16'd1;
    endfunction

endpackage

// File: rtl/core/http_request_field_extractor.sv
// HTTP request field extractor: scans packet bytes and returns the offset
// and length of the URL, Host value or method. Depends on hrfe_pkg.
//
// Result path: a byte is captured in the input stage, then its result goes to the result register.
// Throughput: one byte per cycle unless a byte that yields a result must wait in the single input
// stage because the single result register holds an unread result that out_ready does not take.
// Reset: asynchronous active low; clears packet state, sets the field selector register to url.
module http_request_field_extractor
    import hrfe_pkg::*;
#(
    parameter logic [31:0] MAX_PACKET_BYTES = 32'd65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pkt_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] value_offset,
    output logic [15:0] value_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  field_select
);

    localparam logic [15:0] POS_CAP = (MAX_PACKET_BYTES < 32'd65535) ?
                                      MAX_PACKET_BYTES[15:0] : 16'hFFFF;

    // configuration
    sel_t        sel_reg;

    // input stage
    logic        in_full_reg, in_full_next;
    logic [7:0]  byte_reg;
    logic        last_reg;

    // packet state
    logic        prev_cr_reg, prev_cr_next;
    logic [15:0] pkt_pos_reg, pkt_pos_next;
    logic [15:0] line_start_reg, line_start_next;
    logic [15:0] line_pos_reg, line_pos_next;
    kw_flags_t   flags_reg, flags_next;
    logic [15:0] vlen_reg, vlen_next;
    logic        vend_reg, vend_next;
    logic        done_reg, done_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;

    logic        emit;
    logic        advance;
    status_t     res_status;
    logic [15:0] res_offset;
    logic [15:0] res_length;
    kw_flags_t   flags_hit;
    logic        have;
    logic [2:0]  skip;
    logic        is_delim;
    logic        line_ok;
    logic [16:0] off_sum;

    assign cfg_ready = 1'b1;

    // per-byte scan on the held beat
    always_comb
    begin
        prev_cr_next    = prev_cr_reg;
        pkt_pos_next    = pkt_pos_reg;
        line_start_next = line_start_reg;
        line_pos_next   = line_pos_reg;
        flags_next      = flags_reg;
        vlen_next       = vlen_reg;
        vend_next       = vend_reg;
        done_next       = done_reg;
        emit            = 1'b0;
        res_status      = ST_OK;
        res_offset      = 16'd0;
        res_length      = 16'd0;
        have            = 1'b0;
        skip            = 3'd0;
        line_ok         = 1'b0;
        off_sum         = 17'd0;
        is_delim        = (byte_reg == CH_SP) || (byte_reg == CH_CR) || (byte_reg == CH_LF);

        flags_hit = flags_reg;
        for (int k = 0; k < KW_NUM; k++)
        begin
            if ((line_pos_reg < {13'd0, kw_len(k[1:0])}) &&
                (byte_reg != kw_char(k[1:0], line_pos_reg[2:0])))
            begin
                flags_hit[k[1:0]] = 1'b0;
            end
        end

        case (sel_reg)
            SEL_URL:
            begin
                if (flags_hit[KW_GET])
                begin
                    skip = 3'd4;
                    have = 1'b1;
                end
                else if (flags_hit[KW_POST])
                begin
                    skip = 3'd5;
                    have = 1'b1;
                end
            end
            SEL_HOST:
            begin
                if (flags_hit[KW_HOST])
                begin
                    skip = 3'd6;
                    have = 1'b1;
                end
            end
            default:
            begin
                have = flags_hit[KW_GET] | flags_hit[KW_POST] | flags_hit[KW_HEAD];
            end
        endcase

        if (!done_reg)
        begin
            if (sel_reg == SEL_BAD)
            begin
                emit       = 1'b1;
                res_status = ST_PARAM;
                done_next  = 1'b1;
            end
            else
            begin
                flags_next = flags_hit;
                if (have && (line_pos_reg >= {13'd0, skip}) && !vend_reg)
                begin
                    if (is_delim)
                        vend_next = 1'b1;
                    else
                        vlen_next = sat_inc(vlen_reg, POS_CAP);
                end

                if (byte_reg == CH_LF)
                begin
                    if (prev_cr_reg)
                    begin
                        line_ok = have && ((sel_reg == SEL_METHOD) ?
                                  (line_pos_reg >= 16'd4) : (line_pos_reg >= {13'd0, skip}));
                        off_sum = {1'b0, line_start_reg} + {14'd0, skip};
                        if (line_ok)
                        begin
                            emit       = 1'b1;
                            res_status = ST_OK;
                            res_offset = (off_sum > {1'b0, POS_CAP}) ? POS_CAP : off_sum[15:0];
                            res_length = vlen_next;
                            done_next  = 1'b1;
                        end
                        else if (sel_reg == SEL_URL)
                        begin
                            emit       = 1'b1;
                            res_status = ST_NOT_FOUND;
                            done_next  = 1'b1;
                        end
                    end
                    // restart the line
                    line_start_next = sat_inc(pkt_pos_reg, POS_CAP);
                    line_pos_next   = 16'd0;
                    flags_next      = '1;
                    vlen_next       = 16'd0;
                    vend_next       = 1'b0;
                end
                else
                begin
                    line_pos_next = sat_inc(line_pos_reg, POS_CAP);
                end
                prev_cr_next = (byte_reg == CH_CR);
            end
        end

        pkt_pos_next = sat_inc(pkt_pos_reg, POS_CAP);

        if (last_reg)
        begin
            if (!emit && !done_reg)
            begin
                emit       = 1'b1;
                res_status = ST_NOT_FOUND;
                res_offset = 16'd0;
                res_length = 16'd0;
            end
            // drop all packet state
            prev_cr_next    = 1'b0;
            pkt_pos_next    = 16'd0;
            line_start_next = 16'd0;
            line_pos_next   = 16'd0;
            flags_next      = '1;
            vlen_next       = 16'd0;
            vend_next       = 1'b0;
            done_next       = 1'b0;
        end
    end

    // hold the beat only while a result for it cannot be stored
    assign advance  = in_full_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        offset_next    = offset_reg;
        length_next    = length_reg;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            offset_next    = res_offset;
            length_next    = res_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg        <= SEL_URL;
            in_full_reg    <= 1'b0;
            prev_cr_reg    <= 1'b0;
            pkt_pos_reg    <= 16'd0;
            line_start_reg <= 16'd0;
            line_pos_reg   <= 16'd0;
            flags_reg      <= '1;
            vlen_reg       <= 16'd0;
            vend_reg       <= 1'b0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sel_reg <= field_select;
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                prev_cr_reg    <= prev_cr_next;
                pkt_pos_reg    <= pkt_pos_next;
                line_start_reg <= line_start_next;
                line_pos_reg   <= line_pos_next;
                flags_reg      <= flags_next;
                vlen_reg       <= vlen_next;
                vend_reg       <= vend_next;
                done_reg       <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= pkt_byte;
            last_reg <= last_byte;
        end
        status_reg <= status_next;
        offset_reg <= offset_next;
        length_reg <= length_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign value_offset = offset_reg;
    assign value_length = length_reg;

endmodule
